>>> rtl/bmh_pkg.sv
package bmh_pkg;

  localparam int CAPACITY  = 128;
  localparam int KEY_BITS  = 32;
  localparam int ADDR_BITS = $clog2(CAPACITY);
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);

  typedef logic signed [KEY_BITS-1:0] key_t;
  typedef logic [ADDR_BITS-1:0]       addr_t;
  typedef logic [CNT_BITS-1:0]        count_t;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_CHANGE  = 2'd2,
    OP_REMOVE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Request from the sequencer to the key store.
  typedef struct packed {
    logic  we;
    addr_t waddr;
    key_t  wdata;
    logic  re;
    addr_t raddr;
  } ram_req_t;

  // One finished operation.
  typedef struct packed {
    status_t status;
    key_t    taken;
    key_t    top;
    count_t  count;
  } res_t;

  // Slot of the parent of a nonzero heap slot.
  function automatic addr_t parent_of(addr_t a);
    return addr_t'((a - addr_t'(1)) >> 1);
  endfunction

endpackage

>>> rtl/bmh_ram.sv
module bmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/bmh_cmp.sv
module bmh_cmp (
  input  bmh_pkg::key_t a,
  input  bmh_pkg::key_t b,
  output logic          a_gt_b
);

  // Signed (two's complement) order of two keys, shared by every sift step.
  assign a_gt_b = (a > b);

endmodule

>>> rtl/bmh_seq.sv
module bmh_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  bmh_pkg::op_t      op,
  input  bmh_pkg::key_t     key,
  input  bmh_pkg::addr_t    slot,
  output logic              idle,
  output logic              res_valid,
  input  logic              res_ready,
  output bmh_pkg::res_t     res,
  output bmh_pkg::ram_req_t ram_req,
  input  bmh_pkg::key_t     ram_rdata,
  output bmh_pkg::key_t     cmp_a,
  output bmh_pkg::key_t     cmp_b,
  input  logic              cmp_gt
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CMP,
    S_PUT,
    S_CHG,
    S_REM,
    S_REM_UP,
    S_TAKE,
    S_LAST,
    S_DN_L,
    S_DN_LC,
    S_DN_RC,
    S_DN_MV,
    S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  bmh_pkg::key_t      cur_r, cur_nxt;
  bmh_pkg::addr_t     pos_r, pos_nxt;
  bmh_pkg::count_t    count_r, count_nxt;
  bmh_pkg::addr_t     best_r, best_nxt;
  bmh_pkg::key_t      bestkey_r, bestkey_nxt;
  bmh_pkg::key_t      taken_r, taken_nxt;
  bmh_pkg::status_t   status_r, status_nxt;
  bmh_pkg::key_t      top_r, top_nxt;

  bmh_pkg::count_t    l_idx;
  bmh_pkg::addr_t     l_addr;
  bmh_pkg::addr_t     r_addr;
  bmh_pkg::addr_t     par;
  logic               has_l;
  logic               has_r;

  // Children of the current slot; both child indices may run past CAPACITY.
  assign l_idx  = {pos_r, 1'b1};
  assign l_addr = l_idx[bmh_pkg::ADDR_BITS-1:0];
  assign r_addr = l_addr + bmh_pkg::addr_t'(1);
  assign has_l  = (l_idx < count_r);
  assign has_r  = ({1'b0, l_idx} + {{bmh_pkg::CNT_BITS{1'b0}}, 1'b1}) < {1'b0, count_r};
  assign par    = bmh_pkg::parent_of(pos_r);

  always_comb begin
    cmp_a = ram_rdata;
    cmp_b = cur_r;
    unique case (state_r)
      S_UP_CMP, S_CHG: begin
        cmp_a = cur_r;
        cmp_b = ram_rdata;
      end
      S_DN_RC: begin
        cmp_b = bestkey_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    pos_nxt     = pos_r;
    count_nxt   = count_r;
    best_nxt    = best_r;
    bestkey_nxt = bestkey_r;
    taken_nxt   = taken_r;
    status_nxt  = status_r;
    ram_req     = '0;
    res_valid   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          status_nxt = bmh_pkg::ST_OK;
          taken_nxt  = '0;
          unique case (op)
            bmh_pkg::OP_INSERT: begin
              if (count_r == bmh_pkg::count_t'(bmh_pkg::CAPACITY)) begin
                status_nxt = bmh_pkg::ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                cur_nxt   = key;
                pos_nxt   = count_r[bmh_pkg::ADDR_BITS-1:0];
                count_nxt = count_r + bmh_pkg::count_t'(1);
                if (count_r == '0) begin
                  state_nxt = S_PUT;
                end else begin
                  ram_req.re    = 1'b1;
                  ram_req.raddr = bmh_pkg::parent_of(count_r[bmh_pkg::ADDR_BITS-1:0]);
                  state_nxt     = S_UP_CMP;
                end
              end
            end
            bmh_pkg::OP_EXTRACT: begin
              if (count_r == '0) begin
                status_nxt = bmh_pkg::ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                taken_nxt = top_r;
                state_nxt = S_TAKE;
              end
            end
            bmh_pkg::OP_CHANGE, bmh_pkg::OP_REMOVE: begin
              if (bmh_pkg::count_t'(slot) >= count_r) begin
                status_nxt = bmh_pkg::ST_RANGE;
                state_nxt  = S_DONE;
              end else begin
                cur_nxt       = key;
                pos_nxt       = slot;
                ram_req.re    = 1'b1;
                ram_req.raddr = slot;
                state_nxt     = (op == bmh_pkg::OP_CHANGE) ? S_CHG : S_REM;
              end
            end
          endcase
        end
      end

      S_UP_CMP: begin
        if (cmp_gt) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = pos_r;
          ram_req.wdata = ram_rdata;
          pos_nxt       = par;
          if (par == '0) begin
            state_nxt = S_PUT;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = bmh_pkg::parent_of(par);
          end
        end else begin
          state_nxt = S_PUT;
        end
      end

      S_PUT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = pos_r;
        ram_req.wdata = cur_r;
        state_nxt     = S_DONE;
      end

      S_CHG: begin
        if (cmp_gt) begin
          if (pos_r == '0) begin
            state_nxt = S_PUT;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = par;
            state_nxt     = S_UP_CMP;
          end
        end else begin
          state_nxt = S_DN_L;
        end
      end

      S_REM: begin
        taken_nxt = ram_rdata;
        if (pos_r == '0) begin
          state_nxt = S_TAKE;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = par;
          state_nxt     = S_REM_UP;
        end
      end

      S_REM_UP: begin
        // Ancestors move down one level as the removed key rises.
        ram_req.we    = 1'b1;
        ram_req.waddr = pos_r;
        ram_req.wdata = ram_rdata;
        pos_nxt       = par;
        if (par == '0) begin
          state_nxt = S_TAKE;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = bmh_pkg::parent_of(par);
        end
      end

      S_TAKE: begin
        count_nxt = count_r - bmh_pkg::count_t'(1);
        if (count_r == bmh_pkg::count_t'(1)) begin
          state_nxt = S_DONE;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = count_nxt[bmh_pkg::ADDR_BITS-1:0];
          state_nxt     = S_LAST;
        end
      end

      S_LAST: begin
        cur_nxt   = ram_rdata;
        pos_nxt   = '0;
        state_nxt = S_DN_L;
      end

      S_DN_L: begin
        if (has_l) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = l_addr;
          state_nxt     = S_DN_LC;
        end else begin
          state_nxt = S_PUT;
        end
      end

      S_DN_LC: begin
        if (cmp_gt) begin
          best_nxt    = l_addr;
          bestkey_nxt = ram_rdata;
        end else begin
          best_nxt    = pos_r;
          bestkey_nxt = cur_r;
        end
        if (has_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = r_addr;
          state_nxt     = S_DN_RC;
        end else begin
          state_nxt = S_DN_MV;
        end
      end

      S_DN_RC: begin
        if (cmp_gt) begin
          best_nxt    = r_addr;
          bestkey_nxt = ram_rdata;
        end
        state_nxt = S_DN_MV;
      end

      S_DN_MV: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = pos_r;
        if (best_r == pos_r) begin
          ram_req.wdata = cur_r;
          state_nxt     = S_DONE;
        end else begin
          ram_req.wdata = bestkey_r;
          pos_nxt       = best_r;
          state_nxt     = S_DN_L;
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The root is mirrored so that extract and the result need no extra read.
  always_comb begin
    top_nxt = top_r;
    if (ram_req.we && (ram_req.waddr == '0)) begin
      top_nxt = ram_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      status_r <= bmh_pkg::ST_OK;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
    end
    cur_r     <= cur_nxt;
    pos_r     <= pos_nxt;
    best_r    <= best_nxt;
    bestkey_r <= bestkey_nxt;
    taken_r   <= taken_nxt;
    top_r     <= top_nxt;
  end

  assign idle         = (state_r == S_IDLE);
  assign res.status   = status_r;
  assign res.taken    = taken_r;
  assign res.top      = (count_r == '0) ? '0 : top_r;
  assign res.count    = count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= bmh_pkg::count_t'(bmh_pkg::CAPACITY))
    else $error("heap count above capacity");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
    else $error("key store read and written at one slot in one cycle");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      ((count_r == $past(count_r) + bmh_pkg::count_t'(1)) ||
       (count_r + bmh_pkg::count_t'(1) == $past(count_r))))
    else $error("heap count moved by more than one");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_req.we)
    else $error("key store written while idle");

endmodule

>>> rtl/binary_max_heap_priority_queue.sv
// Binary max-heap priority queue of 128 signed 32-bit keys.
// Input channel (in_valid/in_ready) carries one operation per transfer:
// insert, extract max, change priority at a slot, or remove at a slot.
// Result channel (out_valid/out_ready) returns exactly one result per
// operation: status, the key taken, the new maximum and the key count.
// One operation is worked at a time by a small sequencer that walks the
// heap through a single-port-write, registered-read key store and one
// shared key comparator. in_ready is high only while the sequencer idles.
// Sift-down reads the left child, then the right child, and then writes
// the move, for each heap level, since the key store has one read port.
// The next operation is accepted only once the previous result has
// passed to the output register, so operations never overlap.
// Reset clears the key count, so the heap starts empty; the key store
// itself is not cleared. A finished result sits in an output register;
// while the receiver stalls, the sequencer may accept and work one more
// operation and then holds it until the output register frees up.
module binary_max_heap_priority_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic signed [31:0] in_key_value,
  input  logic [6:0]         in_slot_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_taken_value,
  output logic signed [31:0] out_top_value,
  output logic [7:0]         out_entry_count
);

  bmh_pkg::ram_req_t ram_req;
  bmh_pkg::key_t     ram_rdata;
  bmh_pkg::key_t     cmp_a;
  bmh_pkg::key_t     cmp_b;
  logic              cmp_gt;
  logic              seq_idle;
  logic              start;
  logic              res_valid;
  logic              res_ready;
  bmh_pkg::res_t     res;

  // Output register; it parts the sequencer from a stalled receiver.
  logic              out_valid_r;
  bmh_pkg::res_t     out_res_r;

  assign in_ready  = seq_idle;
  assign start     = in_valid && in_ready;
  assign res_ready = !out_valid_r || out_ready;

  // Key store: one write and one registered read per cycle.
  bmh_ram #(
    .WIDTH (bmh_pkg::KEY_BITS),
    .DEPTH (bmh_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // The single key comparator shared by sift-up and sift-down.
  bmh_cmp u_cmp (
    .a      (cmp_a),
    .b      (cmp_b),
    .a_gt_b (cmp_gt)
  );

  bmh_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .op        (bmh_pkg::op_t'(in_opcode)),
    .key       (bmh_pkg::key_t'(in_key_value)),
    .slot      (bmh_pkg::addr_t'(in_slot_index)),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .cmp_a     (cmp_a),
    .cmp_b     (cmp_b),
    .cmp_gt    (cmp_gt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_taken_value = out_res_r.taken;
  assign out_top_value   = out_res_r.top;
  assign out_entry_count = out_res_r.count;

endmodule

>>> tb/heap_shadow_monitor.sv
`timescale 1ns / 100ps
module heap_shadow_monitor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic signed [31:0] in_key_value,
  input  logic [6:0]         in_slot_index,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_status,
  input  logic signed [31:0] out_taken_value,
  input  logic signed [31:0] out_top_value,
  input  logic [7:0]         out_entry_count,
  output int                 fault_count,
  output int                 awaited_count,
  output int                 heap_size,
  output int                 results_seen,
  output int                 full_rejects,
  output int                 empty_rejects
);

  localparam int REPORT_LIMIT = 10;

  // Shadow copy of the heap, updated at every accepted operation.
  bmh_pkg::key_t heap_keys [bmh_pkg::CAPACITY];
  int            held;
  bmh_pkg::res_t awaited_results [$];

  function automatic void swap_keys(int a, int b);
    bmh_pkg::key_t t;
    t            = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  function automatic void float_up(int pos);
    int up;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (!(heap_keys[pos] > heap_keys[up])) break;
      swap_keys(pos, up);
      pos = up;
    end
  endfunction

  function automatic void sink_down(int pos);
    int best;
    int lft;
    int rgt;
    while (1) begin
      best = pos;
      lft  = 2 * pos + 1;
      rgt  = 2 * pos + 2;
      if (lft < held && heap_keys[lft] > heap_keys[best]) best = lft;
      if (rgt < held && heap_keys[rgt] > heap_keys[best]) best = rgt;
      if (best == pos) break;
      swap_keys(pos, best);
      pos = best;
    end
  endfunction

  function automatic bmh_pkg::key_t pop_root();
    bmh_pkg::key_t peak;
    peak = heap_keys[0];
    held--;
    if (held > 0) begin
      heap_keys[0] = heap_keys[held];
      sink_down(0);
    end
    return peak;
  endfunction

  function automatic bmh_pkg::res_t apply_heap_op(bmh_pkg::op_t op, bmh_pkg::key_t key,
                                                  bmh_pkg::addr_t slot);
    bmh_pkg::res_t r;
    int            pos;
    r.status = bmh_pkg::ST_OK;
    r.taken  = '0;
    case (op)
      bmh_pkg::OP_INSERT: begin
        if (held >= bmh_pkg::CAPACITY) begin
          r.status = bmh_pkg::ST_FULL;
        end else begin
          heap_keys[held] = key;
          held++;
          float_up(held - 1);
        end
      end
      bmh_pkg::OP_EXTRACT: begin
        if (held == 0) r.status = bmh_pkg::ST_EMPTY;
        else r.taken = pop_root();
      end
      default: begin
        if (int'(slot) >= held) begin
          r.status = bmh_pkg::ST_RANGE;
        end else if (op == bmh_pkg::OP_CHANGE) begin
          // A raised key climbs; an equal or lowered one sinks.
          if (key > heap_keys[slot]) begin
            heap_keys[slot] = key;
            float_up(slot);
          end else begin
            heap_keys[slot] = key;
            sink_down(slot);
          end
        end else begin
          // Removal carries the key to the root regardless of order.
          r.taken = heap_keys[slot];
          for (pos = int'(slot); pos > 0; pos = (pos - 1) / 2) swap_keys(pos, (pos - 1) / 2);
          void'(pop_root());
        end
      end
    endcase
    r.top   = (held > 0) ? heap_keys[0] : '0;
    r.count = bmh_pkg::count_t'(held);
    return r;
  endfunction

  always @(posedge clk) begin
    bmh_pkg::res_t want;
    bmh_pkg::res_t got;
    if (!rst_n) begin
      held = 0;
      awaited_results.delete();
      fault_count   <= 0;
      results_seen  <= 0;
      full_rejects  <= 0;
      empty_rejects <= 0;
    end else begin
      if (in_valid && in_ready) begin
        want = apply_heap_op(bmh_pkg::op_t'(in_opcode), in_key_value, in_slot_index);
        if (want.status == bmh_pkg::ST_FULL) full_rejects <= full_rejects + 1;
        if (want.status == bmh_pkg::ST_EMPTY) empty_rejects <= empty_rejects + 1;
        awaited_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        got.status = bmh_pkg::status_t'(out_status);
        got.taken  = out_taken_value;
        got.top    = out_top_value;
        got.count  = out_entry_count;
        results_seen <= results_seen + 1;
        if (awaited_results.size() == 0) begin
          if (fault_count < REPORT_LIMIT)
            $display("%0t: result with nothing outstanding: status %0d taken %0d %s",
                     $time, got.status, got.taken,
                     $sformatf("top %0d count %0d", got.top, got.count));
          fault_count <= fault_count + 1;
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status || got.taken !== want.taken ||
              got.top !== want.top || got.count !== want.count) begin
            if (fault_count < REPORT_LIMIT) begin
              $display("%0t: expected status %0d taken %0d top %0d count %0d", $time,
                       want.status, want.taken, want.top, want.count);
              $display("%0t:   actual status %0d taken %0d top %0d count %0d", $time,
                       got.status, got.taken, got.top, got.count);
            end
            fault_count <= fault_count + 1;
          end
        end
      end
    end
    awaited_count <= awaited_results.size();
    heap_size     <= held;
  end

endmodule

>>> tb/binary_max_heap_priority_queue_tb.sv
`timescale 1ns / 100ps
module binary_max_heap_priority_queue_tb;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 11;
  // The margin covers the slowest operation and long runs of receiver stalls.
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 64;

  localparam bmh_pkg::key_t KEY_HIGHEST = {1'b0, {(bmh_pkg::KEY_BITS - 1){1'b1}}};
  localparam bmh_pkg::key_t KEY_LOWEST  = {1'b1, {(bmh_pkg::KEY_BITS - 1){1'b0}}};

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_opcode;
  logic signed [31:0] in_key_value;
  logic [6:0]         in_slot_index;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_status;
  logic signed [31:0] out_taken_value;
  logic signed [31:0] out_top_value;
  logic [7:0]         out_entry_count;

  int fault_count;
  int awaited_count;
  int heap_size;
  int results_seen;
  int full_rejects;
  int empty_rejects;

  // Percent chance per cycle that the sender holds back or the receiver stalls.
  int sender_gap_pct     = 37;
  int receiver_stall_pct = 51;

  int   ops_issued [4];
  int   stall_cycles = 0;
  // The random traffic alternates between growing the heap until it is full
  // and shrinking it until it is empty, so that every depth gets exercised.
  logic heap_filling;

  binary_max_heap_priority_queue uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_key_value    (in_key_value),
    .in_slot_index   (in_slot_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_taken_value (out_taken_value),
    .out_top_value   (out_top_value),
    .out_entry_count (out_entry_count)
  );

  // The monitor keeps its own heap, predicts every result and compares.
  heap_shadow_monitor u_shadow (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_key_value    (in_key_value),
    .in_slot_index   (in_slot_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_taken_value (out_taken_value),
    .out_top_value   (out_top_value),
    .out_entry_count (out_entry_count),
    .fault_count     (fault_count),
    .awaited_count   (awaited_count),
    .heap_size       (heap_size),
    .results_seen    (results_seen),
    .full_rejects    (full_rejects),
    .empty_rejects   (empty_rejects)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // The receiver decides at every falling edge whether it takes a result
  // at the next rising edge.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Watchdog: any cycle with a transfer on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
               stall_cycles, awaited_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Presents one operation and returns at the falling edge after its
  // transfer. Valid is left high so that a back-to-back operation never
  // lowers and raises it within one time step; only a gap lowers it.
  task automatic send_op(bmh_pkg::op_t op, bmh_pkg::key_t key, bmh_pkg::addr_t slot);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_key_value  <= key;
    in_slot_index <= slot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    ops_issued[op]++;
  endtask

  // Random operations whose mix follows the fill or drain direction.
  // Keys lean toward the extremes and a narrow band around zero so that
  // ties come up often; slots mostly land inside the heap.
  task automatic run_random(int items);
    int             pick;
    bmh_pkg::op_t   op;
    bmh_pkg::key_t  key;
    bmh_pkg::addr_t slot;
    for (int n = 0; n < items; n++) begin
      if (heap_filling && heap_size == bmh_pkg::CAPACITY && $urandom_range(3) == 0)
        heap_filling = 1'b0;
      else if (!heap_filling && heap_size == 0 && $urandom_range(2) == 0)
        heap_filling = 1'b1;

      pick = $urandom_range(99);
      if (heap_filling) begin
        op = (pick < 80) ? bmh_pkg::OP_INSERT : (pick < 90) ? bmh_pkg::OP_EXTRACT :
             (pick < 97) ? bmh_pkg::OP_CHANGE : bmh_pkg::OP_REMOVE;
      end else begin
        op = (pick < 15) ? bmh_pkg::OP_INSERT : (pick < 65) ? bmh_pkg::OP_EXTRACT :
             (pick < 80) ? bmh_pkg::OP_CHANGE : bmh_pkg::OP_REMOVE;
      end

      case ($urandom_range(9))
        0: key = KEY_HIGHEST;
        1: key = KEY_LOWEST;
        2, 3, 4: key = int'($urandom_range(16)) - 8;
        default: key = $urandom();
      endcase

      if (heap_size > 0 && $urandom_range(9) < 8)
        slot = bmh_pkg::addr_t'($urandom_range(heap_size - 1));
      else
        slot = bmh_pkg::addr_t'($urandom_range(bmh_pkg::CAPACITY - 1));

      send_op(op, key, slot);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = bmh_pkg::OP_INSERT;
    in_key_value  = '0;
    in_slot_index = '0;
    heap_filling  = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Errors on an empty heap come first.
    send_op(bmh_pkg::OP_EXTRACT, 0, 7'd0);
    send_op(bmh_pkg::OP_CHANGE, 1, 7'd0);
    send_op(bmh_pkg::OP_REMOVE, 0, 7'd0);
    // A single key at the root: equal, raised and lowered priority.
    send_op(bmh_pkg::OP_INSERT, 42, 7'd0);
    send_op(bmh_pkg::OP_CHANGE, 42, 7'd0);
    send_op(bmh_pkg::OP_CHANGE, 100, 7'd0);
    send_op(bmh_pkg::OP_CHANGE, 7, 7'd0);
    send_op(bmh_pkg::OP_EXTRACT, 0, 7'd0);
    // Both key extremes, zero, minus one and a tied pair.
    send_op(bmh_pkg::OP_INSERT, KEY_HIGHEST, 7'd0);
    send_op(bmh_pkg::OP_INSERT, KEY_LOWEST, 7'd127);
    send_op(bmh_pkg::OP_INSERT, 0, 7'd0);
    send_op(bmh_pkg::OP_INSERT, -1, 7'd0);
    send_op(bmh_pkg::OP_INSERT, 5, 7'd0);
    send_op(bmh_pkg::OP_INSERT, 5, 7'd0);
    // Six keys held: the top slot index and the slot just past the end.
    send_op(bmh_pkg::OP_CHANGE, 0, 7'd127);
    send_op(bmh_pkg::OP_REMOVE, 0, 7'd6);
    // A leaf raised to tie the root must stop below it; the root then sinks.
    send_op(bmh_pkg::OP_CHANGE, KEY_HIGHEST, 7'd5);
    send_op(bmh_pkg::OP_CHANGE, KEY_LOWEST, 7'd0);
    // Removal at the root, at the last slot and in the middle.
    send_op(bmh_pkg::OP_REMOVE, 0, 7'd0);
    send_op(bmh_pkg::OP_REMOVE, 0, 7'd4);
    send_op(bmh_pkg::OP_REMOVE, 0, 7'd1);
    send_op(bmh_pkg::OP_CHANGE, KEY_LOWEST, 7'd1);
    send_op(bmh_pkg::OP_EXTRACT, 0, 7'd0);
    send_op(bmh_pkg::OP_EXTRACT, 0, 7'd0);
    send_op(bmh_pkg::OP_EXTRACT, 0, 7'd0);

    // Random part under three idle mixes: sender-light, receiver-light,
    // and none at all.
    run_random(270);
    sender_gap_pct     = 51;
    receiver_stall_pct = 37;
    run_random(270);
    sender_gap_pct     = 0;
    receiver_stall_pct = 0;
    run_random(260);
    in_valid <= 1'b0;

    // Wait for every outstanding result, then leave room for a stray one.
    while (awaited_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d operations: %0d insert, %0d extract, %0d change, %0d remove.",
             ops_issued[bmh_pkg::OP_INSERT] + ops_issued[bmh_pkg::OP_EXTRACT] +
             ops_issued[bmh_pkg::OP_CHANGE] + ops_issued[bmh_pkg::OP_REMOVE],
             ops_issued[bmh_pkg::OP_INSERT], ops_issued[bmh_pkg::OP_EXTRACT],
             ops_issued[bmh_pkg::OP_CHANGE], ops_issued[bmh_pkg::OP_REMOVE]);
    $display("Compared %0d results (%0d full-heap and %0d empty-heap rejections), %0d faults.",
             results_seen, full_rejects, empty_rejects, fault_count);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/bmh_pkg.sv
rtl/bmh_ram.sv
rtl/bmh_cmp.sv
rtl/bmh_seq.sv
rtl/binary_max_heap_priority_queue.sv
tb/heap_shadow_monitor.sv
tb/binary_max_heap_priority_queue_tb.sv
